// ===== sv/ccfs_pkg.sv =====
`default_nettype none

package ccfs_pkg;

   // Instruction kinds; the spare code has no member and is treated as undefined
   typedef enum logic [2:0] {
      KIND_UNDEF = 3'd0,
      KIND_BRK   = 3'd1,
      KIND_JMP   = 3'd2,
      KIND_JSR   = 3'd3,
      KIND_NOP   = 3'd4,
      KIND_RTI   = 3'd5,
      KIND_RTS   = 3'd6
   } kind_type;

   // Spare kind code, undefined like KIND_UNDEF
   localparam logic [2:0] KIND_SPARE = 3'd7;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_HI,
      ST_PUSH_LO,
      ST_PUSH_FL,
      ST_POP_FL,
      ST_POP_LO,
      ST_POP_HI,
      ST_POP_END,
      ST_DONE
   } state_type;

   localparam int FLAG_I_BIT = 2;
   localparam int FLAG_D_BIT = 3;

   // One stack access per cycle: read always, write when wr_en
   typedef struct packed {
      logic       wr_en;
      logic [7:0] ptr;
      logic [7:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  flags;
      logic [7:0]  sp;
      logic        bad;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/ccfs_stack_mem.sv =====
`default_nettype none

module ccfs_stack_mem #(
   parameter int STACK_DEPTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ccfs_pkg::mem_req_type mem_req,
   output logic [7:0]                rd_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [11:0] DEPTH_W = 12'(STACK_DEPTH);

   logic [7:0]             stack_ff [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] valid_ff;
   logic [7:0]             rd_data_ff;
   logic [AW-1:0]          slot;

   // Reduce the 8-bit pointer modulo the depth by conditional subtraction (exact for depths of 16 or more)
   always_comb begin
      logic [11:0] rem;
      logic [11:0] step;
      rem = {4'd0, mem_req.ptr};
      for (int k = 3; k >= 0; k--) begin
         step = DEPTH_W << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      slot = rem[AW-1:0];
   end

   // Write the addressed byte
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         stack_ff[slot] <= mem_req.wr_data;
      end
   end

   // Mark written entries; reset makes the whole page read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[slot] <= 1'b1;
      end
   end

   // Register read data
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[slot] ? stack_ff[slot] : 8'd0;
   end

   assign rd_data = rd_data_ff;

`ifndef SYNTHESIS
   a_reset_clears_page: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("stack page not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== sv/ccfs_seq.sv =====
`default_nettype none

module ccfs_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_kind,
   input  wire logic [15:0]           req_pc_in,
   input  wire logic [7:0]            req_flags_in,
   input  wire logic [7:0]            req_sp_in,
   input  wire logic [15:0]           req_target_address,
   output ccfs_pkg::mem_req_type      mem_req,
   input  wire logic [7:0]            rd_data,
   output logic                       res_valid,
   output ccfs_pkg::result_type       res,
   input  wire logic                  res_free
);

   ccfs_pkg::state_type state_ff, state_in;
   ccfs_pkg::kind_type  kind_ff, kind_in;
   logic [15:0]         pc_ff, pc_in;
   logic [7:0]          flags_ff, flags_in;
   logic [7:0]          sp_ff, sp_in;
   logic [15:0]         target_ff, target_in;
   logic [7:0]          lo_ff, lo_in;
   logic [15:0]         push_word;

   // BRK pushes the current PC, JSR the return address PC+2
   assign push_word = (kind_ff == ccfs_pkg::KIND_BRK) ? pc_ff : pc_ff + 16'd2;

   // Next state, stack accesses and result
   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      pc_in            = pc_ff;
      flags_in         = flags_ff;
      sp_in            = sp_ff;
      target_in        = target_ff;
      lo_in            = lo_ff;
      req_stall        = 1'b1;
      mem_req.wr_en    = 1'b0;
      mem_req.ptr      = sp_ff;
      mem_req.wr_data  = push_word[15:8];
      res_valid        = 1'b0;
      res.pc           = pc_ff;
      res.flags        = flags_ff;
      res.sp           = sp_ff;
      res.bad          = 1'b0;

      unique case (kind_ff)
         ccfs_pkg::KIND_BRK: begin
            res.pc    = pc_ff + 16'd2;
            res.flags = flags_ff;
            res.flags[ccfs_pkg::FLAG_I_BIT] = 1'b1;
            res.flags[ccfs_pkg::FLAG_D_BIT] = 1'b0;
         end
         ccfs_pkg::KIND_JMP, ccfs_pkg::KIND_JSR: res.pc = target_ff;
         ccfs_pkg::KIND_RTS:                     res.pc = pc_ff + 16'd1;
         ccfs_pkg::KIND_RTI, ccfs_pkg::KIND_NOP: res.pc = pc_ff;
         default:                                res.bad = 1'b1;
      endcase

      unique case (state_ff)
         ccfs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               kind_in   = ccfs_pkg::kind_type'(req_kind);
               pc_in     = req_pc_in;
               flags_in  = req_flags_in;
               sp_in     = req_sp_in;
               target_in = req_target_address;
               unique case (ccfs_pkg::kind_type'(req_kind))
                  ccfs_pkg::KIND_BRK, ccfs_pkg::KIND_JSR: state_in = ccfs_pkg::ST_PUSH_HI;
                  ccfs_pkg::KIND_RTI:                     state_in = ccfs_pkg::ST_POP_FL;
                  ccfs_pkg::KIND_RTS:                     state_in = ccfs_pkg::ST_POP_LO;
                  default:                                state_in = ccfs_pkg::ST_DONE;
               endcase
            end
         end
         ccfs_pkg::ST_PUSH_HI: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = push_word[15:8];
            sp_in           = sp_ff - 8'd1;
            state_in        = ccfs_pkg::ST_PUSH_LO;
         end
         ccfs_pkg::ST_PUSH_LO: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = push_word[7:0];
            sp_in           = sp_ff - 8'd1;
            state_in        = (kind_ff == ccfs_pkg::KIND_BRK) ? ccfs_pkg::ST_PUSH_FL
                                                              : ccfs_pkg::ST_DONE;
         end
         ccfs_pkg::ST_PUSH_FL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = flags_ff;
            sp_in           = sp_ff - 8'd1;
            state_in        = ccfs_pkg::ST_DONE;
         end
         ccfs_pkg::ST_POP_FL: begin
            mem_req.ptr = sp_ff + 8'd1;
            sp_in       = sp_ff + 8'd1;
            state_in    = ccfs_pkg::ST_POP_LO;
         end
         ccfs_pkg::ST_POP_LO: begin
            // capture the status byte read in the previous step
            if (kind_ff == ccfs_pkg::KIND_RTI) begin
               flags_in = rd_data;
            end
            mem_req.ptr = sp_ff + 8'd1;
            sp_in       = sp_ff + 8'd1;
            state_in    = ccfs_pkg::ST_POP_HI;
         end
         ccfs_pkg::ST_POP_HI: begin
            lo_in       = rd_data;
            mem_req.ptr = sp_ff + 8'd1;
            sp_in       = sp_ff + 8'd1;
            state_in    = ccfs_pkg::ST_POP_END;
         end
         ccfs_pkg::ST_POP_END: begin
            pc_in    = {rd_data, lo_ff};
            state_in = ccfs_pkg::ST_DONE;
         end
         ccfs_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_free) begin
               state_in = ccfs_pkg::ST_IDLE;
            end
         end
         default: state_in = ccfs_pkg::ST_IDLE;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold instruction payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pc_ff     <= pc_in;
      flags_ff  <= flags_in;
      sp_ff     <= sp_in;
      target_ff <= target_in;
      lo_ff     <= lo_in;
   end

`ifndef SYNTHESIS
   a_no_stack_kinds_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccfs_pkg::ST_IDLE && req_valid &&
       (req_kind == 3'(ccfs_pkg::KIND_JMP) || req_kind == 3'(ccfs_pkg::KIND_NOP) ||
        req_kind == 3'(ccfs_pkg::KIND_UNDEF) || req_kind == ccfs_pkg::KIND_SPARE))
      |=> state_ff == ccfs_pkg::ST_DONE)
      else $error("stackless instruction did not go straight to done");

   a_push_decrements: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |=> sp_ff == $past(sp_ff) - 8'd1)
      else $error("push did not decrement the stack pointer");
`endif

endmodule

`default_nettype wire

// ===== sv/cpu_control_flow_stack_unit.sv =====
`default_nettype none

// After the request transfer the sequencer moves N stack bytes (3 BRK/RTI, 2 JSR/RTS,
// 0 JMP/NOP/undefined); pops take an extra step for the registered stack read. The
// result waits in the done state until the output register is empty or drained.
// Only one instruction is in flight; the next transfer is taken in the cycle after
// the result enters the output register.
// Reset (synchronous): sequencer idles, output empties, stack page reads as zero.
module cpu_control_flow_stack_unit #(
   parameter int STACK_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [15:0] req_pc_in,
   input  wire logic [7:0]  req_flags_in,
   input  wire logic [7:0]  req_sp_in,
   input  wire logic [15:0] req_target_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pc_out,
   output logic [7:0]       rsp_flags_out,
   output logic [7:0]       rsp_sp_out,
   output logic             rsp_bad_opcode
);

   ccfs_pkg::mem_req_type mem_req;
   ccfs_pkg::result_type  res;
   ccfs_pkg::result_type  rsp_ff;
   logic                  rd_data_unused_guard;
   logic [7:0]            rd_data;
   logic                  res_valid;
   logic                  res_free;
   logic                  res_load;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign rd_data_unused_guard = 1'b0;

   ccfs_stack_mem #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ccfs_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_pc_in          (req_pc_in),
      .req_flags_in       (req_flags_in),
      .req_sp_in          (req_sp_in),
      .req_target_address (req_target_address),
      .mem_req            (mem_req),
      .rd_data            (rd_data),
      .res_valid          (res_valid),
      .res                (res),
      .res_free           (res_free | rd_data_unused_guard)
   );

   // Output register takes a result when empty or being drained
   assign res_free = !rsp_valid_ff || !rsp_stall;
   assign res_load = res_valid && res_free;

   always_comb begin
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pc_out     = rsp_ff.pc;
   assign rsp_flags_out  = rsp_ff.flags;
   assign rsp_sp_out     = rsp_ff.sp;
   assign rsp_bad_opcode = rsp_ff.bad;

`ifndef SYNTHESIS
   a_rsp_from_sequencer: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(res_valid))
      else $error("transfer shown without a finished instruction");

   a_busy_while_done: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_stall)
      else $error("request taken while a result is pending in the sequencer");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;

   localparam int STACK_DEPTH = 256;
   localparam int RANDOM_ITEMS = 650;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int LONG_HOLD_AFTER = 250;
   localparam int DRAIN_ITEM = 400;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] pc;
      logic [7:0]  flags;
      logic [7:0]  sp;
      logic [15:0] target;
      int          gap;
      logic        drain;
   } instr_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = ccfs_pkg::KIND_NOP;
   logic [15:0] req_pc_in = '0;
   logic [7:0]  req_flags_in = '0;
   logic [7:0]  req_sp_in = '0;
   logic [15:0] req_target_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_pc_out;
   logic [7:0]  rsp_flags_out;
   logic [7:0]  rsp_sp_out;
   logic        rsp_bad_opcode;
   logic        long_hold = 1'b0;

   // Stack copy for prediction, cleared like the block's stack page
   logic [7:0]  model_stack [STACK_DEPTH];

   instr_type             pending_instrs [$];
   ccfs_pkg::result_type  expected_results [$];
   instr_type             staged_instr;
   instr_type             bus_instr;
   logic        staged_loaded = 1'b0;
   int          staged_gap = 0;
   int          accepted_count = 0;
   int          result_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          rsp_stall_left = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic [7:0]  track_sp;
   logic [2:0]  open_frames [$];

   cpu_control_flow_stack_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_pc_in(req_pc_in),
      .req_flags_in(req_flags_in),
      .req_sp_in(req_sp_in),
      .req_target_address(req_target_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pc_out(rsp_pc_out),
      .rsp_flags_out(rsp_flags_out),
      .rsp_sp_out(rsp_sp_out),
      .rsp_bad_opcode(rsp_bad_opcode)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic stack_push(inout logic [7:0] sp, input logic [7:0] value);
      model_stack[sp % STACK_DEPTH] = value;
      sp = sp - 8'd1;
   endtask

   task automatic stack_pop(inout logic [7:0] sp, output logic [7:0] value);
      sp = sp + 8'd1;
      value = model_stack[sp % STACK_DEPTH];
   endtask

   // Execute one control-flow instruction on the local stack copy
   task automatic execute_control_flow(input instr_type it,
                                       output ccfs_pkg::result_type res);
      logic [7:0]  sp;
      logic [7:0]  fl;
      logic [15:0] pc;
      logic [15:0] ret;
      logic [7:0]  lo;
      logic [7:0]  hi;
      sp = it.sp;
      fl = it.flags;
      pc = it.pc;
      res.bad = 1'b0;
      case (it.kind)
         ccfs_pkg::KIND_BRK: begin
            stack_push(sp, pc[15:8]);
            stack_push(sp, pc[7:0]);
            stack_push(sp, fl);
            fl[ccfs_pkg::FLAG_I_BIT] = 1'b1;
            fl[ccfs_pkg::FLAG_D_BIT] = 1'b0;
            pc = pc + 16'd2;
         end
         ccfs_pkg::KIND_JMP: begin
            pc = it.target;
         end
         ccfs_pkg::KIND_JSR: begin
            ret = pc + 16'd2;
            stack_push(sp, ret[15:8]);
            stack_push(sp, ret[7:0]);
            pc = it.target;
         end
         ccfs_pkg::KIND_NOP: begin
         end
         ccfs_pkg::KIND_RTI: begin
            stack_pop(sp, fl);
            stack_pop(sp, lo);
            stack_pop(sp, hi);
            pc = {hi, lo};
         end
         ccfs_pkg::KIND_RTS: begin
            stack_pop(sp, lo);
            stack_pop(sp, hi);
            pc = {hi, lo} + 16'd1;
         end
         default: begin
            res.bad = 1'b1;
         end
      endcase
      res.pc = pc;
      res.flags = fl;
      res.sp = sp;
   endtask

   task automatic queue_instr(input logic [2:0] kind, input logic [15:0] pc,
                              input logic [7:0] flags, input logic [7:0] sp,
                              input logic [15:0] target, input int gap,
                              input logic drain);
      instr_type it;
      it.kind = kind;
      it.pc = pc;
      it.flags = flags;
      it.sp = sp;
      it.target = target;
      it.gap = gap;
      it.drain = drain;
      pending_instrs.push_back(it);
   endtask

   // Mostly nested call/return programs that follow a running stack pointer,
   // mixed with undefined codes, stray returns and reseated pointers
   task automatic queue_random_program();
      logic [2:0]  kind;
      logic [7:0]  sp;
      logic [2:0]  top;
      int          roll;
      int          gap;
      logic        drain;
      track_sp = 8'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gap = ((n / 60) % 3 == 2) ? 0 : $urandom_range(0, 7);
         drain = (n == DRAIN_ITEM) || ($urandom_range(0, 49) == 0);
         roll = $urandom_range(0, 99);
         sp = track_sp;
         if (roll < 3) begin
            // reseat the pointer and forget open frames
            track_sp = 8'($urandom);
            open_frames.delete();
            sp = track_sp;
            kind = ccfs_pkg::KIND_NOP;
         end else if (roll < 10) begin
            kind = 3'($urandom_range(0, 7));
            sp = 8'($urandom);
         end else if (roll < 16) begin
            kind = $urandom_range(0, 1) ? ccfs_pkg::KIND_JMP : ccfs_pkg::KIND_NOP;
         end else if (roll < 21) begin
            kind = $urandom_range(0, 1) ? ccfs_pkg::KIND_RTI : ccfs_pkg::KIND_RTS;
         end else if (open_frames.size() < 30 &&
                      (open_frames.size() == 0 || $urandom_range(0, 1) == 1)) begin
            kind = $urandom_range(0, 1) ? ccfs_pkg::KIND_BRK : ccfs_pkg::KIND_JSR;
            open_frames.push_back(kind);
         end else begin
            top = open_frames.pop_back();
            kind = (top == ccfs_pkg::KIND_BRK) ? ccfs_pkg::KIND_RTI : ccfs_pkg::KIND_RTS;
         end
         if (roll >= 16 && roll < 21 && open_frames.size() > 0) begin
            top = open_frames.pop_back();
         end
         if (roll >= 10) begin
            case (kind)
               ccfs_pkg::KIND_BRK: track_sp = track_sp - 8'd3;
               ccfs_pkg::KIND_JSR: track_sp = track_sp - 8'd2;
               ccfs_pkg::KIND_RTI: track_sp = track_sp + 8'd3;
               ccfs_pkg::KIND_RTS: track_sp = track_sp + 8'd2;
               default: begin
               end
            endcase
         end
         queue_instr(kind, 16'($urandom), 8'($urandom), sp, 16'($urandom), gap, drain);
      end
   endtask

   // Stimulus, reset and end of run
   initial begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         model_stack[i] = 8'h00;
      end
      // returns from a stack that was never written read zeros
      queue_instr(ccfs_pkg::KIND_RTS, 16'h1234, 8'h5a, 8'h40, 16'hffff, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTI, 16'hffff, 8'hff, 8'h50, 16'h0000, 0, 1'b0);
      // undefined codes, NOP and JMP at the field extremes
      queue_instr(ccfs_pkg::KIND_UNDEF, 16'hffff, 8'hff, 8'h00, 16'hffff, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_SPARE, 16'h0000, 8'h00, 8'hff, 16'h0000, 2, 1'b0);
      queue_instr(ccfs_pkg::KIND_SPARE, 16'hffff, 8'hff, 8'hff, 16'hffff, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_NOP, 16'hffff, 8'hff, 8'hff, 16'hffff, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_NOP, 16'h0000, 8'h00, 8'h00, 16'h0000, 1, 1'b0);
      queue_instr(ccfs_pkg::KIND_JMP, 16'hffff, 8'hff, 8'h80, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_JMP, 16'h0000, 8'h00, 8'h7f, 16'hffff, 0, 1'b0);
      // break with pointer crossing zero, pc wrap, then return from it
      queue_instr(ccfs_pkg::KIND_BRK, 16'hffff, 8'hff, 8'h01, 16'ha5a5, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTI, 16'h0000, 8'h00, 8'hfe, 16'h0000, 3, 1'b0);
      queue_instr(ccfs_pkg::KIND_BRK, 16'h8001, 8'h00, 8'hff, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTI, 16'h0000, 8'h00, 8'hfc, 16'hffff, 0, 1'b0);
      // subroutine returns with pc wrap on the push and on the pop
      queue_instr(ccfs_pkg::KIND_JSR, 16'hfffe, 8'h33, 8'h00, 16'hffff, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTS, 16'hffff, 8'h33, 8'hfe, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_JSR, 16'hfffd, 8'hcc, 8'h10, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTS, 16'h0000, 8'hcc, 8'h0e, 16'h1111, 7, 1'b0);
      // nested call inside a break, returned in order
      queue_instr(ccfs_pkg::KIND_BRK, 16'h4321, 8'h08, 8'h90, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_JSR, 16'h0100, 8'h0c, 8'h8d, 16'hbeef, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTS, 16'hbeef, 8'h0c, 8'h8b, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTI, 16'h0103, 8'h0c, 8'h8d, 16'h0000, 0, 1'b0);
      // pop across the top of the pointer range
      queue_instr(ccfs_pkg::KIND_RTI, 16'h0000, 8'h00, 8'hff, 16'h0000, 0, 1'b0);
      queue_instr(ccfs_pkg::KIND_RTS, 16'h0000, 8'h00, 8'hfe, 16'h0000, 0, 1'b1);
      queue_random_program();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || staged_loaded || req_valid ||
             expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS cpu_control_flow_stack_unit");
      end else begin
         $display("FAIL cpu_control_flow_stack_unit");
      end
      $finish;
   end

   // Request driver: predict on each transfer, then stage and offer the next item
   always @(posedge clock) begin
      ccfs_pkg::result_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            execute_control_flow(bus_instr, res);
            expected_results.push_back(res);
            accepted_count++;
         end
         if (!staged_loaded && pending_instrs.size() != 0) begin
            staged_instr = pending_instrs.pop_front();
            staged_gap = staged_instr.gap;
            staged_loaded = 1'b1;
         end
         if (staged_loaded && staged_gap == 0 &&
             (!staged_instr.drain || expected_results.size() == 0)) begin
            bus_instr = staged_instr;
            staged_loaded = 1'b0;
            req_valid <= 1'b1;
            req_kind <= bus_instr.kind;
            req_pc_in <= bus_instr.pc;
            req_flags_in <= bus_instr.flags;
            req_sp_in <= bus_instr.sp;
            req_target_address <= bus_instr.target;
         end else begin
            req_valid <= 1'b0;
            if (staged_loaded && staged_gap != 0) begin
               staged_gap--;
            end
         end
      end
   end

   // Long receiver hold-off once the run is under way
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
      end else begin
         if (!hold_done && accepted_count >= LONG_HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         long_hold <= (hold_left != 0);
         if (hold_left != 0) begin
            hold_left--;
         end
      end
   end

   // Result monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      ccfs_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected result: pc %h flags %h sp %h bad %b",
                           rsp_pc_out, rsp_flags_out, rsp_sp_out, rsp_bad_opcode);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_pc_out !== want.pc || rsp_flags_out !== want.flags ||
                   rsp_sp_out !== want.sp || rsp_bad_opcode !== want.bad) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display({"result %0d mismatch: expected pc %h flags %h sp %h bad %b,",
                               " got pc %h flags %h sp %h bad %b"},
                              result_count, want.pc, want.flags, want.sp, want.bad,
                              rsp_pc_out, rsp_flags_out, rsp_sp_out, rsp_bad_opcode);
                  end
               end
            end
            result_count++;
            rsp_stall_left = ((result_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
         end
         rsp_stall <= long_hold || (rsp_stall_left != 0);
         if (rsp_stall_left != 0) begin
            rsp_stall_left--;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL cpu_control_flow_stack_unit");
         $finish;
      end
   end

endmodule
